// ----- rtl/core/esev_pkg.sv -----
// ----------------------------------------------------------------------------
// esev_pkg
// Shared types and constants of the encoded slot evaluator.
// ----------------------------------------------------------------------------
package esev_pkg;

    localparam int DATA_W     = 21;
    localparam int DIM        = 128;
    localparam int PHI        = 256;
    localparam int XY_MOD     = 4 * DIM;
    localparam int W_MOD      = PHI + 1;
    localparam int INNER_W    = $clog2(PHI);
    localparam int MID_W      = $clog2(DIM);
    localparam int CNT_W      = $clog2(DATA_W + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int GEN_W      = 11;
    localparam int MAT_W      = 8;
    localparam int IDX_W      = 7;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODULUS  = 3'd0,
        REG_ZETA     = 3'd1,
        REG_ETA      = 3'd2,
        REG_WGEN     = 3'd3,
        REG_BRANCH   = 3'd4,
        REG_MATRIX   = 3'd5,
        REG_ROW      = 3'd6,
        REG_COLUMN   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] zeta_root;
        logic [DATA_W-1:0] eta_root;
        logic [GEN_W-1:0]  w_generator;
        logic              branch_select;
        logic [MAT_W-1:0]  matrix_index;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  column_index;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              last;
        logic              bad;
    } item_t;

    function automatic logic [DATA_W-1:0] one_mod(input logic [DATA_W-1:0] m);
        return (m > DATA_W'(1)) ? DATA_W'(1) : '0;
    endfunction

endpackage

// ----- rtl/core/esev_front.sv -----
// ----------------------------------------------------------------------------
// esev_front
// Accepts input words, flags noncanonical residues and queues them.
// ----------------------------------------------------------------------------
module esev_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [esev_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic [esev_pkg::DATA_W-1:0]    modulus,
    output logic                           q_valid,
    output esev_pkg::item_t                q_head,
    input  logic                           q_pop
);

    esev_pkg::item_t                entry_reg [esev_pkg::QDEPTH];
    logic [esev_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [esev_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [esev_pkg::QPTR_W:0]      count_reg;
    esev_pkg::item_t                in_item;
    logic                           push;

    always_comb begin
        in_item.re   = s_tdata[esev_pkg::DATA_W-1:0];
        in_item.im   = s_tdata[2*esev_pkg::DATA_W-1:esev_pkg::DATA_W];
        in_item.last = s_tlast;
        in_item.bad  = (in_item.re >= modulus) || (in_item.im >= modulus);
    end

    assign s_tready = (count_reg != (esev_pkg::QPTR_W+1)'(esev_pkg::QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_head   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == esev_pkg::QPTR_W'(esev_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == esev_pkg::QPTR_W'(esev_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/esev_mulmod.sv -----
// ----------------------------------------------------------------------------
// esev_mulmod
// Bit-serial modular multiplier, one bit of the multiplier per cycle.
// An operand a that is not below the modulus is first reduced in its own pass.
// ----------------------------------------------------------------------------
module esev_mulmod (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [esev_pkg::DATA_W-1:0] a,
    input  logic [esev_pkg::DATA_W-1:0] b,
    input  logic [esev_pkg::DATA_W-1:0] m,
    output logic                        done,
    output logic [esev_pkg::DATA_W-1:0] result
);

    logic [esev_pkg::DATA_W-1:0] a_reg, b_reg, m_reg, r_reg;
    logic [esev_pkg::CNT_W-1:0]  cnt_reg;
    logic                        run_reg, done_reg, red_reg;
    logic [esev_pkg::DATA_W+1:0] acc, sub1, sub2, m_ext;

    always_comb begin
        m_ext = {2'b00, m_reg};
        acc   = {1'b0, r_reg, 1'b0} +
                (red_reg ? {{(esev_pkg::DATA_W+1){1'b0}}, a_reg[esev_pkg::DATA_W-1]} :
                 (b_reg[esev_pkg::DATA_W-1] ? {2'b00, a_reg} : '0));
        sub1  = (acc >= m_ext) ? acc - m_ext : acc;
        sub2  = (sub1 >= m_ext) ? sub1 - m_ext : sub1;
    end

    assign done   = done_reg;
    assign result = (m_reg == '0) ? '0 : r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            red_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg   <= a;
                b_reg   <= b;
                m_reg   <= m;
                r_reg   <= '0;
                cnt_reg <= esev_pkg::CNT_W'(esev_pkg::DATA_W);
                red_reg <= (m != '0) && (a >= m);
                run_reg <= 1'b1;
            end else if (run_reg && red_reg) begin
                if (cnt_reg == esev_pkg::CNT_W'(1)) begin
                    a_reg   <= sub2[esev_pkg::DATA_W-1:0];
                    r_reg   <= '0;
                    cnt_reg <= esev_pkg::CNT_W'(esev_pkg::DATA_W);
                    red_reg <= 1'b0;
                end else begin
                    a_reg   <= {a_reg[esev_pkg::DATA_W-2:0], 1'b0};
                    r_reg   <= sub2[esev_pkg::DATA_W-1:0];
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end else if (run_reg) begin
                r_reg   <= sub2[esev_pkg::DATA_W-1:0];
                b_reg   <= {b_reg[esev_pkg::DATA_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == esev_pkg::CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/esev_back.sv -----
// ----------------------------------------------------------------------------
// esev_back
// Sequencer that sets up the evaluation points and accumulates each word.
// ----------------------------------------------------------------------------
module esev_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  esev_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    input  esev_pkg::item_t             q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [esev_pkg::DATA_W-1:0] slot_value,
    output logic                        count_error,
    output logic                        residue_error
);

    localparam int W = esev_pkg::DATA_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PT_SETUP, ST_PW_RED, ST_PW_TEST, ST_PW_R, ST_PW_B, ST_PT_STORE,
        ST_IT_RE, ST_IT_IM, ST_IT_II, ST_IT_LANE, ST_IT_P, ST_IT_TERM, ST_IT_ACC,
        ST_IT_AR, ST_IT_W, ST_IT_Y, ST_IT_X, ST_IT_XY, ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        PT_EX, PT_EY, PT_EW, PT_X, PT_Y, PT_W, PT_XI, PT_YI, PT_WI, PT_GU
    } pt_step_t;

    state_t   state_reg;
    pt_step_t ps_reg, ps_next;
    logic     issued_reg;

    logic [W-1:0] pow_base_reg, pow_exp_reg, pow_m_reg, pow_r_reg;
    logic [W-1:0] tmp_re_reg, tmp_im_reg;
    logic [W-1:0] acc_reg, x_step_reg, y_step_reg, w_step_reg, gu_reg;
    logic [W-1:0] x_pow_reg, y_pow_reg, w_pow_reg, xy_reg;
    logic [esev_pkg::MID_W-1:0]   outer_reg, middle_reg;
    logic [esev_pkg::INNER_W-1:0] inner_reg;
    logic points_ready_reg, bad_seen_reg, full_reg, at_final_reg;
    logic m_tvalid_reg, cerr_reg, rerr_reg;
    logic [W-1:0] slot_reg;

    logic [W-1:0] t, inv, mul_a, mul_b, mul_m, mul_res;
    logic [W-1:0] set_base, set_exp, set_m;
    logic [W-1:0] add_a, add_b, add_res, sub_res, lane;
    logic [W:0]   sum;
    logic         mul_start, mul_done, mul_ok, is_mul, at_final, out_free, result_load;

    assign t        = cfg.modulus;
    assign inv      = (t >= W'(2)) ? t - W'(2) : '0;
    assign is_mul   = state_reg inside {ST_PW_RED, ST_PW_R, ST_PW_B, ST_IT_RE, ST_IT_IM,
                                        ST_IT_II, ST_IT_P, ST_IT_TERM, ST_IT_AR, ST_IT_W,
                                        ST_IT_Y, ST_IT_X, ST_IT_XY};
    assign mul_start = is_mul && !issued_reg;
    assign mul_ok    = issued_reg && mul_done;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_pop     = (state_reg == ST_FIN) && (!q_head.last || out_free);
    assign result_load = (state_reg == ST_FIN) && q_head.last && out_free;
    assign at_final  = (outer_reg == esev_pkg::MID_W'(esev_pkg::DIM - 1)) &&
                       (middle_reg == esev_pkg::MID_W'(esev_pkg::DIM - 1)) &&
                       (inner_reg == esev_pkg::INNER_W'(esev_pkg::PHI - 1));

    assign m_tvalid      = m_tvalid_reg;
    assign slot_value    = slot_reg;
    assign count_error   = cerr_reg;
    assign residue_error = rerr_reg;

    esev_mulmod u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .m       (mul_m),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_m = t;
        case (state_reg)
            ST_PW_RED: begin
                mul_a = esev_pkg::one_mod(pow_m_reg); mul_b = pow_base_reg; mul_m = pow_m_reg;
            end
            ST_PW_R: begin
                mul_a = pow_r_reg; mul_b = pow_base_reg; mul_m = pow_m_reg;
            end
            ST_PW_B: begin
                mul_a = pow_base_reg; mul_b = pow_base_reg; mul_m = pow_m_reg;
            end
            ST_IT_RE:   begin mul_a = esev_pkg::one_mod(t); mul_b = q_head.re; end
            ST_IT_IM:   begin mul_a = esev_pkg::one_mod(t); mul_b = q_head.im; end
            ST_IT_II:   begin mul_a = gu_reg;     mul_b = tmp_im_reg; end
            ST_IT_P:    begin mul_a = xy_reg;     mul_b = w_pow_reg;  end
            ST_IT_TERM: begin mul_a = tmp_re_reg; mul_b = tmp_im_reg; end
            ST_IT_AR:   begin mul_a = esev_pkg::one_mod(t); mul_b = acc_reg; end
            ST_IT_W:    begin mul_a = w_pow_reg;  mul_b = w_step_reg; end
            ST_IT_Y:    begin mul_a = y_pow_reg;  mul_b = y_step_reg; end
            ST_IT_X:    begin mul_a = x_pow_reg;  mul_b = x_step_reg; end
            ST_IT_XY:   begin mul_a = x_pow_reg;  mul_b = y_pow_reg;  end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        set_base = cfg.zeta_root;
        set_exp  = '0;
        set_m    = t;
        ps_next  = PT_GU;
        case (ps_reg)
            PT_EX: begin
                set_base = W'(5); set_exp = W'(cfg.row_index);
                set_m = W'(esev_pkg::XY_MOD); ps_next = PT_EY;
            end
            PT_EY: begin
                set_base = W'(5); set_exp = W'(cfg.column_index);
                set_m = W'(esev_pkg::XY_MOD); ps_next = PT_EW;
            end
            PT_EW: begin
                set_base = W'(cfg.w_generator); set_exp = W'(cfg.matrix_index);
                set_m = W'(esev_pkg::W_MOD); ps_next = PT_X;
            end
            PT_X:  begin set_exp = x_step_reg; ps_next = PT_Y; end
            PT_Y:  begin set_exp = y_step_reg; ps_next = PT_W; end
            PT_W: begin
                set_base = cfg.eta_root; set_exp = w_step_reg;
                ps_next = cfg.branch_select ? PT_XI : PT_GU;
            end
            PT_XI: begin set_base = x_step_reg; set_exp = inv; ps_next = PT_YI; end
            PT_YI: begin set_base = y_step_reg; set_exp = inv; ps_next = PT_WI; end
            PT_WI: begin set_base = w_step_reg; set_exp = inv; ps_next = PT_GU; end
            PT_GU: begin set_exp = W'(esev_pkg::DIM); ps_next = PT_GU; end
            default: begin
                set_exp = '0;
            end
        endcase
    end

    always_comb begin
        add_a   = (state_reg == ST_IT_ACC) ? acc_reg : tmp_re_reg;
        add_b   = tmp_im_reg;
        sum     = {1'b0, add_a} + {1'b0, add_b};
        add_res = (t == '0) ? '0 :
                  ((sum >= {1'b0, t}) ? W'(sum - {1'b0, t}) : W'(sum));
        sub_res = (t == '0) ? '0 :
                  ((add_a >= add_b) ? add_a - add_b : t - (add_b - add_a));
        lane    = cfg.branch_select ? sub_res : add_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ps_reg           <= PT_EX;
            issued_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            acc_reg          <= '0;
            x_step_reg       <= '0;
            y_step_reg       <= '0;
            w_step_reg       <= '0;
            gu_reg           <= '0;
            x_pow_reg        <= W'(1);
            y_pow_reg        <= W'(1);
            w_pow_reg        <= W'(1);
            xy_reg           <= W'(1);
            outer_reg        <= '0;
            middle_reg       <= '0;
            inner_reg        <= '0;
            points_ready_reg <= 1'b0;
            bad_seen_reg     <= 1'b0;
            full_reg         <= 1'b0;
            at_final_reg     <= 1'b0;
        end else begin
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (mul_start) begin
                issued_reg <= 1'b1;
            end else if (mul_ok) begin
                issued_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        at_final_reg <= 1'b0;
                        if (full_reg) begin
                            state_reg <= ST_FIN;
                        end else if (!points_ready_reg) begin
                            ps_reg    <= PT_EX;
                            state_reg <= ST_PT_SETUP;
                        end else begin
                            state_reg <= ST_IT_RE;
                        end
                    end
                end
                ST_PT_SETUP: begin
                    pow_base_reg <= set_base;
                    pow_exp_reg  <= set_exp;
                    pow_m_reg    <= set_m;
                    pow_r_reg    <= esev_pkg::one_mod(set_m);
                    state_reg    <= ST_PW_RED;
                end
                ST_PW_RED: begin
                    if (mul_ok) begin
                        pow_base_reg <= mul_res;
                        state_reg    <= ST_PW_TEST;
                    end
                end
                ST_PW_TEST: begin
                    if (pow_exp_reg == '0) begin
                        state_reg <= ST_PT_STORE;
                    end else if (pow_exp_reg[0]) begin
                        state_reg <= ST_PW_R;
                    end else begin
                        state_reg <= ST_PW_B;
                    end
                end
                ST_PW_R: begin
                    if (mul_ok) begin
                        pow_r_reg <= mul_res;
                        state_reg <= ST_PW_B;
                    end
                end
                ST_PW_B: begin
                    if (mul_ok) begin
                        pow_base_reg <= mul_res;
                        pow_exp_reg  <= pow_exp_reg >> 1;
                        state_reg    <= ST_PW_TEST;
                    end
                end
                ST_PT_STORE: begin
                    case (ps_reg)
                        PT_EX, PT_X, PT_XI: x_step_reg <= pow_r_reg;
                        PT_EY, PT_Y, PT_YI: y_step_reg <= pow_r_reg;
                        PT_EW, PT_W, PT_WI: w_step_reg <= pow_r_reg;
                        default: gu_reg <= pow_r_reg;
                    endcase
                    if (ps_reg == PT_GU) begin
                        points_ready_reg <= 1'b1;
                        state_reg        <= ST_IT_RE;
                    end else begin
                        ps_reg    <= ps_next;
                        state_reg <= ST_PT_SETUP;
                    end
                end
                ST_IT_RE: begin
                    if (mul_ok) begin
                        tmp_re_reg <= mul_res;
                        state_reg  <= ST_IT_IM;
                    end
                end
                ST_IT_IM: begin
                    if (mul_ok) begin
                        tmp_im_reg <= mul_res;
                        state_reg  <= ST_IT_II;
                    end
                end
                ST_IT_II: begin
                    if (mul_ok) begin
                        tmp_im_reg <= mul_res;
                        state_reg  <= ST_IT_LANE;
                    end
                end
                ST_IT_LANE: begin
                    tmp_re_reg <= lane;
                    state_reg  <= ST_IT_P;
                end
                ST_IT_P: begin
                    if (mul_ok) begin
                        tmp_im_reg <= mul_res;
                        state_reg  <= ST_IT_TERM;
                    end
                end
                ST_IT_TERM: begin
                    if (mul_ok) begin
                        tmp_im_reg <= mul_res;
                        state_reg  <= ST_IT_ACC;
                    end
                end
                ST_IT_ACC: begin
                    if ((t != '0) && (acc_reg >= t)) begin
                        state_reg <= ST_IT_AR;
                    end else begin
                        acc_reg      <= add_res;
                        at_final_reg <= at_final;
                        if (at_final) begin
                            full_reg <= 1'b1;
                        end
                        state_reg <= ST_IT_W;
                    end
                end
                ST_IT_AR: begin
                    if (mul_ok) begin
                        acc_reg   <= mul_res;
                        state_reg <= ST_IT_ACC;
                    end
                end
                ST_IT_W: begin
                    if (mul_ok) begin
                        if (inner_reg == esev_pkg::INNER_W'(esev_pkg::PHI - 1)) begin
                            inner_reg <= '0;
                            w_pow_reg <= W'(1);
                            state_reg <= ST_IT_Y;
                        end else begin
                            inner_reg <= inner_reg + 1'b1;
                            w_pow_reg <= mul_res;
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_IT_Y: begin
                    if (mul_ok) begin
                        if (middle_reg == esev_pkg::MID_W'(esev_pkg::DIM - 1)) begin
                            middle_reg <= '0;
                            y_pow_reg  <= W'(1);
                            state_reg  <= ST_IT_X;
                        end else begin
                            middle_reg <= middle_reg + 1'b1;
                            y_pow_reg  <= mul_res;
                            state_reg  <= ST_IT_XY;
                        end
                    end
                end
                ST_IT_X: begin
                    if (mul_ok) begin
                        x_pow_reg <= mul_res;
                        outer_reg <= outer_reg + 1'b1;
                        state_reg <= ST_IT_XY;
                    end
                end
                ST_IT_XY: begin
                    if (mul_ok) begin
                        xy_reg    <= mul_res;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!q_head.last) begin
                        bad_seen_reg <= bad_seen_reg | q_head.bad;
                        state_reg    <= ST_IDLE;
                    end else if (out_free) begin
                        slot_reg         <= acc_reg;
                        cerr_reg         <= !at_final_reg;
                        rerr_reg         <= bad_seen_reg | q_head.bad;
                        acc_reg          <= '0;
                        x_step_reg       <= '0;
                        y_step_reg       <= '0;
                        w_step_reg       <= '0;
                        gu_reg           <= '0;
                        x_pow_reg        <= W'(1);
                        y_pow_reg        <= W'(1);
                        w_pow_reg        <= W'(1);
                        xy_reg           <= W'(1);
                        outer_reg        <= '0;
                        middle_reg       <= '0;
                        inner_reg        <= '0;
                        points_ready_reg <= 1'b0;
                        bad_seen_reg     <= 1'b0;
                        full_reg         <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/encoded_slot_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// encoded_slot_evaluator_top
// Decodes one slot of a dense Gaussian plaintext modulo a runtime prime.
//
//   Channel   Direction  Payload
//   s_*       in         tdata: real, imag; tlast: last coefficient
//   m_*       out        tdata: slot value; tuser: count error, residue error
//   apb       in/out     eight configuration registers at 4*i
//
// Every modular product goes through one bit-serial multiplier, which first
// reduces its first operand in its own pass when that operand is not below
// the modulus; this happens only after the modulus changes within a plaintext
// or while the modulus is one. After such a change the accumulator can also
// need one reduction product. A coefficient takes six products, plus up to
// three more when a row or a matrix ends. The first coefficient of a
// plaintext also sets up the points: up to ten exponentiations, each up to 43 products.
// A two-word queue keeps the input accepting while the sequencer works; a full
// output register stalls the sequencer only on a last coefficient.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module encoded_slot_evaluator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [esev_pkg::S_TDATA_W-1:0]  s_tdata,   // real_part, imag_part
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [esev_pkg::M_TDATA_W-1:0]  m_tdata,   // slot_value
    output logic [1:0]                      m_tuser,   // count_error, residue_error
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [esev_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [esev_pkg::APB_DATA_W-1:0] pwdata,
    output logic [esev_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int W = esev_pkg::DATA_W;

    esev_pkg::cfg_t     cfg_reg;
    esev_pkg::reg_idx_t reg_idx;
    esev_pkg::item_t    q_head;
    logic               q_valid, q_pop, cfg_wr;
    logic [W-1:0]       slot_value;
    logic               count_error, residue_error;

    assign pready  = 1'b1;
    assign reg_idx = esev_pkg::reg_idx_t'(paddr[esev_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modulus       <= W'(1579009);
            cfg_reg.zeta_root     <= '0;
            cfg_reg.eta_root      <= '0;
            cfg_reg.w_generator   <= esev_pkg::GEN_W'(3);
            cfg_reg.branch_select <= 1'b0;
            cfg_reg.matrix_index  <= '0;
            cfg_reg.row_index     <= '0;
            cfg_reg.column_index  <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                esev_pkg::REG_MODULUS: cfg_reg.modulus      <= pwdata[W-1:0];
                esev_pkg::REG_ZETA:    cfg_reg.zeta_root    <= pwdata[W-1:0];
                esev_pkg::REG_ETA:     cfg_reg.eta_root     <= pwdata[W-1:0];
                esev_pkg::REG_WGEN:
                    cfg_reg.w_generator <= pwdata[esev_pkg::GEN_W-1:0];
                esev_pkg::REG_BRANCH:  cfg_reg.branch_select <= pwdata[0];
                esev_pkg::REG_MATRIX:
                    cfg_reg.matrix_index <= pwdata[esev_pkg::MAT_W-1:0];
                esev_pkg::REG_ROW:     cfg_reg.row_index <= pwdata[esev_pkg::IDX_W-1:0];
                esev_pkg::REG_COLUMN:
                    cfg_reg.column_index <= pwdata[esev_pkg::IDX_W-1:0];
                default: cfg_reg.modulus <= cfg_reg.modulus;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            esev_pkg::REG_MODULUS: prdata = 32'(cfg_reg.modulus);
            esev_pkg::REG_ZETA:    prdata = 32'(cfg_reg.zeta_root);
            esev_pkg::REG_ETA:     prdata = 32'(cfg_reg.eta_root);
            esev_pkg::REG_WGEN:    prdata = 32'(cfg_reg.w_generator);
            esev_pkg::REG_BRANCH:  prdata = 32'(cfg_reg.branch_select);
            esev_pkg::REG_MATRIX:  prdata = 32'(cfg_reg.matrix_index);
            esev_pkg::REG_ROW:     prdata = 32'(cfg_reg.row_index);
            esev_pkg::REG_COLUMN:  prdata = 32'(cfg_reg.column_index);
            default:               prdata = '0;
        endcase
    end

    esev_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .modulus  (cfg_reg.modulus),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    esev_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .slot_value    (slot_value),
        .count_error   (count_error),
        .residue_error (residue_error)
    );

    assign m_tdata = esev_pkg::M_TDATA_W'(slot_value);
    assign m_tuser = {residue_error, count_error};

    a_pop_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("queue popped while empty");

    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_pop)) else $error("result without a consumed word");

    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid) else $error("queue full but no head word");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams short Gaussian plaintexts into the encoded slot evaluator and checks
// every decoded slot, count flag and residue flag against a behavioral model
// kept in step with each accepted word, under random and extreme settings.
// ----------------------------------------------------------------------------
module testbench;
    import esev_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] slot;
        bit                count_err;
        bit                residue_err;
    } slot_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // real_part, imag_part
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // slot_value
    logic [1:0]            m_tuser;        // count_error, residue_error
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    encoded_slot_evaluator_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register shadow.
    longint unsigned t_mod, zeta, eta, wgen, branch, mat_idx, row_idx, col_idx;
    // Decoder shadow.
    longint unsigned acc, x_stp, y_stp, w_stp, unit_i, x_pw, y_pw, w_pw, xy_pw;
    int unsigned     n_outer, n_mid, n_inner;
    bit              points_set, bad_seen, stream_done;

    slot_result_t slot_queue[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_cycles = 0;

    function automatic longint unsigned mulm(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
        return (m == 0) ? 0 : (a * b) % m;
    endfunction

    function automatic longint unsigned powm(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
        longint unsigned r;
        if (m == 0) return 0;
        r = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) r = mulm(r, b, m);
            b = mulm(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic void clear_decoder();
        acc = 0;
        x_stp = 0; y_stp = 0; w_stp = 0; unit_i = 0;
        x_pw = 1; y_pw = 1; w_pw = 1; xy_pw = 1;
        n_outer = 0; n_mid = 0; n_inner = 0;
        points_set = 0; bad_seen = 0; stream_done = 0;
    endfunction

    // Advances the decoder shadow by one coefficient; returns 1 with a result.
    function automatic bit decode_coefficient(longint unsigned re_raw, longint unsigned im_raw,
                                              bit last, output slot_result_t res);
        longint unsigned t, re, im, ii, lane, term, inv;
        bit at_final, extra;
        t = t_mod;
        at_final = 0;
        extra = 0;
        if (!points_set) begin
            inv = (t >= 2) ? t - 2 : 0;
            x_stp = powm(zeta, powm(5, row_idx, XY_MOD), t);
            y_stp = powm(zeta, powm(5, col_idx, XY_MOD), t);
            w_stp = powm(eta, powm(wgen, mat_idx, W_MOD), t);
            if (branch[0]) begin
                x_stp = powm(x_stp, inv, t);
                y_stp = powm(y_stp, inv, t);
                w_stp = powm(w_stp, inv, t);
            end
            unit_i = powm(zeta, DIM, t);
            points_set = 1;
        end
        if (re_raw >= t || im_raw >= t) bad_seen = 1;
        if (stream_done) begin
            extra = 1;
        end else begin
            re = (t != 0) ? re_raw % t : 0;
            im = (t != 0) ? im_raw % t : 0;
            ii = mulm(unit_i, im, t);
            if (t == 0) lane = 0;
            else if (branch[0]) lane = (re >= ii) ? re - ii : t - (ii - re);
            else lane = (re + ii) % t;
            term = mulm(lane, mulm(xy_pw, w_pw, t), t);
            acc = (t == 0) ? 0 : (acc + term) % t;
            at_final = (n_outer == DIM - 1) && (n_mid == DIM - 1) && (n_inner == PHI - 1);
            w_pw = mulm(w_pw, w_stp, t);
            n_inner++;
            if (n_inner >= PHI) begin
                n_inner = 0;
                w_pw = 1;
                y_pw = mulm(y_pw, y_stp, t);
                n_mid++;
                if (n_mid >= DIM) begin
                    n_mid = 0;
                    y_pw = 1;
                    x_pw = mulm(x_pw, x_stp, t);
                    n_outer++;
                end
                xy_pw = mulm(x_pw, y_pw, t);
            end
            if (at_final) stream_done = 1;
        end
        if (!last) return 0;
        res.slot = acc[DATA_W-1:0];
        res.count_err = !at_final || extra;
        res.residue_err = bad_seen;
        clear_decoder();
        return 1;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge aclk) begin
        slot_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (slot_queue.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[DATA_W-1:0], 0);
            end else begin
                want = slot_queue.pop_front();
                if (m_tdata[DATA_W-1:0] !== want.slot)
                    report_mismatch("slot_value", m_tdata[DATA_W-1:0], want.slot);
                if (m_tuser[0] !== want.count_err)
                    report_mismatch("count_error", m_tuser[0], want.count_err);
                if (m_tuser[1] !== want.residue_err)
                    report_mismatch("residue_error", m_tuser[1], want.residue_err);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODULUS: t_mod   = value[DATA_W-1:0];
            REG_ZETA:    zeta    = value[DATA_W-1:0];
            REG_ETA:     eta     = value[DATA_W-1:0];
            REG_WGEN:    wgen    = value[GEN_W-1:0];
            REG_BRANCH:  branch  = value[0];
            REG_MATRIX:  mat_idx = value[MAT_W-1:0];
            REG_ROW:     row_idx = value[IDX_W-1:0];
            REG_COLUMN:  col_idx = value[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_word(logic [DATA_W-1:0] re, logic [DATA_W-1:0] im, bit last);
        slot_result_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, im, re};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        if (decode_coefficient(re, im, last, res)) slot_queue = {slot_queue, res};
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (slot_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_residue();
        if (t_mod > 1 && $urandom_range(9) != 0)
            return DATA_W'($urandom_range(32'(t_mod - 1)));
        return DATA_W'($urandom_range(2 ** DATA_W - 1));
    endfunction

    task automatic send_plaintext(int len);
        for (int k = 0; k < len; k++) send_word(pick_residue(), pick_residue(), k == len - 1);
    endtask

    task automatic random_settings();
        longint unsigned primes[7] = '{3, 7681, 12289, 65537, 786433, 1579009, 2097143};
        write_reg(REG_MODULUS, ($urandom_range(7) == 0) ? $urandom_range(2 ** DATA_W - 1)
                                                        : APB_DATA_W'(primes[$urandom_range(6)]));
        write_reg(REG_ZETA, $urandom_range(2 ** DATA_W - 1));
        write_reg(REG_ETA, $urandom_range(2 ** DATA_W - 1));
        write_reg(REG_WGEN, $urandom_range(2 ** GEN_W - 1));
        write_reg(REG_BRANCH, $urandom_range(1));
        write_reg(REG_MATRIX, $urandom_range(2 ** MAT_W - 1));
        write_reg(REG_ROW, $urandom_range(2 ** IDX_W - 1));
        write_reg(REG_COLUMN, $urandom_range(2 ** IDX_W - 1));
    endtask

    task automatic test_reset_settings();
        send_word(5, 7, 0);
        send_word(0, 0, 0);
        send_word(2 ** DATA_W - 1, 1, 1);
        drain_results();
    endtask

    task automatic test_extremes();
        write_reg(REG_MODULUS, 2097143);
        write_reg(REG_ZETA, 2 ** DATA_W - 1);
        write_reg(REG_ETA, 123457);
        write_reg(REG_WGEN, 2 ** GEN_W - 1);
        write_reg(REG_BRANCH, 1);
        write_reg(REG_MATRIX, 2 ** MAT_W - 1);
        write_reg(REG_ROW, 2 ** IDX_W - 1);
        write_reg(REG_COLUMN, 2 ** IDX_W - 1);
        send_word(0, 0, 0);
        send_word(2097142, 2097142, 0);
        send_word(1, 2097142, 1);
        send_word(2 ** DATA_W - 1, 0, 1);
        drain_results();
        write_reg(REG_BRANCH, 0);
        write_reg(REG_WGEN, 0);
        write_reg(REG_MATRIX, 0);
        write_reg(REG_ROW, 0);
        write_reg(REG_COLUMN, 0);
        send_word(2097142, 2097142, 0);
        send_word(1, 0, 1);
        drain_results();
    endtask

    task automatic test_degenerate_modulus();
        write_reg(REG_MODULUS, 0);
        send_word(9, 2 ** DATA_W - 1, 0);
        send_word(0, 0, 1);
        drain_results();
        write_reg(REG_MODULUS, 1);
        write_reg(REG_BRANCH, 1);
        send_word(0, 0, 0);
        send_word(1, 0, 1);
        drain_results();
    endtask

    task automatic test_change_mid_plaintext();
        write_reg(REG_MODULUS, 12289);
        write_reg(REG_ZETA, 1945);
        write_reg(REG_ETA, 4050);
        write_reg(REG_WGEN, 3);
        write_reg(REG_BRANCH, 0);
        send_word(100, 200, 0);
        send_word(12288, 3, 0);
        s_tvalid <= 1'b0;
        // Let the setup and both words finish before the registers move.
        repeat (20000) @(posedge aclk);
        write_reg(REG_MODULUS, 7681);
        write_reg(REG_BRANCH, 1);
        write_reg(REG_ROW, 5);
        send_word(7000, 50, 1);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_MODULUS, 65537);
        hold_cycles = 20000;
        for (int k = 0; k < 8; k++) send_word(pick_residue(), pick_residue(), 1);
        drain_results();
    endtask

    task automatic test_random_plaintexts(int budget, int sidle, int ridle);
        int sent = 0;
        int frames = 0;
        int len;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        while (sent < budget) begin
            if (frames % 6 == 0) begin
                drain_results();
                random_settings();
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            send_plaintext(len);
            sent += len;
            frames++;
            if ($urandom_range(7) == 0) drain_results();
        end
        drain_results();
    endtask

    initial begin
        int guard;
        t_mod = 1579009; zeta = 0; eta = 0; wgen = 3;
        branch = 0; mat_idx = 0; row_idx = 0; col_idx = 0;
        clear_decoder();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_extremes();
        test_degenerate_modulus();
        test_change_mid_plaintext();
        test_output_backpressure();
        test_random_plaintexts(400, 35, 85);
        test_random_plaintexts(400, 85, 35);
        test_random_plaintexts(400, 0, 0);
        guard = 0;
        while (slot_queue.size() != 0 && guard < 1000000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);
        if (error_count == 0 && slot_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/esev_pkg.sv
rtl/core/esev_front.sv
rtl/core/esev_mulmod.sv
rtl/core/esev_back.sv
rtl/core/encoded_slot_evaluator_top.sv
tb/sv/testbench.sv
